// ----- design/iqdc_pkg.sv -----
// Shared constants, types and fixed-point helpers for the IQ downconverter.
package iqdc_pkg;

   // Filter and oscillator dimensions
   localparam int TAPS          = 63;
   localparam int TAP_AW        = $clog2(TAPS);
   localparam int TAP_IDX_W     = 6;
   localparam int RENORM_PERIOD = 1024;
   localparam int RENORM_W      = $clog2(RENORM_PERIOD);
   localparam int DECIM_MAX     = 16;
   localparam int DECIM_W       = 5;
   localparam int DCNT_W        = 4;

   // Field and datapath widths
   localparam int BYTE_W      = 8;
   localparam int SAMPLE_W    = 9;
   localparam int LINE_W      = 10;
   localparam int OSC_W       = 16;
   localparam int COEFF_W     = 16;
   localparam int OUT_W       = 16;
   localparam int FACT_W      = 32;
   localparam int PROD_W      = OSC_W + FACT_W;
   localparam int OSC_ACC_W   = PROD_W + 2;
   localparam int FIR_PROD_W  = COEFF_W + LINE_W;
   localparam int FIR_ACC_W   = FIR_PROD_W + $clog2(TAPS);

   // Transaction queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION = 2'd2;

   // Input action codes
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_LOAD   = 1'b1;

   // Reset values
   localparam logic signed [OSC_W-1:0] OSC_ONE = 16'sd32767;
   localparam logic [DECIM_W-1:0] DECIM_RESET  = 5'd1;

   typedef enum logic {
      KIND_SAMPLE,
      KIND_LOAD
   } kind_type;

   typedef struct packed {
      logic signed [OSC_W-1:0] step_cos;
      logic signed [OSC_W-1:0] step_sin;
      logic [DECIM_W-1:0]      decimation;  // already clamped to 1..16
   } cfg_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [SAMPLE_W-1:0] ci;
      logic signed [SAMPLE_W-1:0] cq;
      logic [TAP_AW-1:0]         idx;
      logic signed [COEFF_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic en;
      logic clr;
      logic sub;
   } mac_ctl_type;

   typedef enum logic [4:0] {
      B_IDLE,
      B_MIX_I0,
      B_MIX_I1,
      B_MIX_Q0,
      B_MIX_Q1,
      B_ADV_R0,
      B_ADV_R1,
      B_ADV_I0,
      B_ADV_I1,
      B_UPDATE,
      B_NORM_M0,
      B_NORM_M1,
      B_NORM_F,
      B_NORM_R,
      B_NORM_I,
      B_NORM_END,
      B_FIR,
      B_DRAIN,
      B_EMIT
   } back_state_type;

   // Round half up by 2^s, then clamp to lo..hi
   function automatic logic signed [OSC_ACC_W-1:0] rnd_sat(
      input logic signed [OSC_ACC_W-1:0] acc,
      input int                          s,
      input logic signed [OSC_ACC_W-1:0] lo,
      input logic signed [OSC_ACC_W-1:0] hi
   );
      logic signed [OSC_ACC_W-1:0] half;
      logic signed [OSC_ACC_W-1:0] t;
      half = OSC_ACC_W'(1) << (s - 1);
      t    = (acc + half) >>> s;
      if (t > hi) begin
         rnd_sat = hi;
      end else if (t < lo) begin
         rnd_sat = lo;
      end else begin
         rnd_sat = t;
      end
   endfunction

   localparam logic signed [OSC_ACC_W-1:0] MIX_MAX = 511;
   localparam logic signed [OSC_ACC_W-1:0] MIX_MIN = -512;
   localparam logic signed [OSC_ACC_W-1:0] W16_MAX = 32767;
   localparam logic signed [OSC_ACC_W-1:0] W16_MIN = -32768;
   localparam logic signed [OSC_ACC_W-1:0] THREE_HALF_SCALE = OSC_ACC_W'(3) << 30;

endpackage

// ----- design/iqdc_ifs.sv -----
// Request and response channel interfaces of the IQ downconverter.
interface iqdc_req_if import iqdc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [BYTE_W-1:0]         i_byte;
   logic [BYTE_W-1:0]         q_byte;
   logic [TAP_IDX_W-1:0]      tap_index;
   logic signed [COEFF_W-1:0] tap_value;

   modport source (output valid, action, i_byte, q_byte, tap_index, tap_value,
                   input ready);
   modport sink   (input valid, action, i_byte, q_byte, tap_index, tap_value,
                   output ready);
endinterface

interface iqdc_rsp_if import iqdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] out_i;
   logic signed [OUT_W-1:0] out_q;

   modport source (output valid, out_i, out_q, input ready);
   modport sink   (input valid, out_i, out_q, output ready);
endinterface

// ----- design/iqdc_queue.sv -----
// Short transaction queue between the front and back parts.
module iqdc_queue import iqdc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type head
);

   entry_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/iqdc_front.sv -----
// Front part: accepts request transactions, centres samples, screens tap loads.
module iqdc_front import iqdc_pkg::*; (
   iqdc_req_if.sink  req_chan,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   logic accept;
   logic idx_ok;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign idx_ok         = int'(req_chan.tap_index) < TAPS;

   // Classify and centre as 2*raw - 255
   always_comb begin
      q_entry.kind  = (req_chan.action == ACTION_LOAD) ? KIND_LOAD : KIND_SAMPLE;
      q_entry.ci    = SAMPLE_W'($signed({1'b0, req_chan.i_byte, 1'b0}) - 10'sd255);
      q_entry.cq    = SAMPLE_W'($signed({1'b0, req_chan.q_byte, 1'b0}) - 10'sd255);
      q_entry.idx   = TAP_AW'(req_chan.tap_index);
      q_entry.value = req_chan.tap_value;
      // Drop loads aimed past the last tap
      q_push = accept && ((req_chan.action == ACTION_SAMPLE) || idx_ok);
   end

endmodule

// ----- design/iqdc_back.sv -----
// Back part: oscillator mixing, delay line, tap store and shared FIR MAC.
module iqdc_back import iqdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_empty,
   input  entry_type  q_head,
   output logic       q_pop,
   iqdc_rsp_if.source rsp_chan
);

   back_state_type state_ff, state_in;

   // Oscillator and counters
   logic signed [OSC_W-1:0]     osc_r_ff, osc_i_ff;
   logic [RENORM_W-1:0]         renorm_cnt_ff, renorm_cnt_in;
   logic [DCNT_W-1:0]           decim_cnt_ff, decim_cnt_in;
   logic [DECIM_W-1:0]          decim_next;
   logic                        renorm_hit, fir_hit, fir_due_ff;

   // Shared oscillator multiplier
   logic signed [SAMPLE_W-1:0]  ci_ff, cq_ff;
   logic signed [OSC_W-1:0]     mul_a;
   logic signed [FACT_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]    prod;
   logic signed [OSC_ACC_W-1:0] acc_ff, acc_in, acc_base;
   mac_ctl_type                 mac;
   logic signed [LINE_W-1:0]    mi_ff, mq_ff;
   logic signed [OSC_W-1:0]     nr_ff, rtmp_ff;
   logic signed [FACT_W-1:0]    f_ff;

   // Delay line and tap store
   logic [2*LINE_W-1:0]         line_mem [TAPS];
   logic signed [COEFF_W-1:0]   coeff_mem [TAPS];
   logic [TAPS-1:0]             line_vld_ff, coeff_vld_ff;
   logic [TAP_AW-1:0]           wp_ff, wp_in;
   logic [TAP_AW-1:0]           jp_ff, rp_ff;
   logic                        rd_pend_ff;
   logic [2*LINE_W-1:0]         ln_rd_ff;
   logic                        ln_v_ff;
   logic signed [COEFF_W-1:0]   cf_rd_ff;
   logic                        cf_v_ff;
   logic signed [COEFF_W-1:0]   cf_use;
   logic signed [LINE_W-1:0]    li_use, lq_use;
   logic signed [FIR_ACC_W-1:0] fir_i_ff, fir_q_ff;

   // Result register
   logic                        out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0]     out_i_ff, out_q_ff;
   logic                        slot_free;

   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign decim_next = {1'b0, decim_cnt_ff} + 1'b1;
   assign fir_hit    = decim_next >= cfg.decimation;
   assign renorm_hit = renorm_cnt_ff == RENORM_W'(RENORM_PERIOD - 1);
   assign wp_in      = (wp_ff == '0) ? TAP_AW'(TAPS - 1) : wp_ff - 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && q_head.kind == KIND_SAMPLE) begin
               state_in = B_MIX_I0;
            end
         end
         B_MIX_I0:  state_in = B_MIX_I1;
         B_MIX_I1:  state_in = B_MIX_Q0;
         B_MIX_Q0:  state_in = B_MIX_Q1;
         B_MIX_Q1:  state_in = B_ADV_R0;
         B_ADV_R0:  state_in = B_ADV_R1;
         B_ADV_R1:  state_in = B_ADV_I0;
         B_ADV_I0:  state_in = B_ADV_I1;
         B_ADV_I1:  state_in = B_UPDATE;
         B_UPDATE: begin
            priority if (renorm_hit) begin
               state_in = B_NORM_M0;
            end else if (fir_hit) begin
               state_in = B_FIR;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_NORM_M0: state_in = B_NORM_M1;
         B_NORM_M1: state_in = B_NORM_F;
         B_NORM_F:  state_in = B_NORM_R;
         B_NORM_R:  state_in = B_NORM_I;
         B_NORM_I:  state_in = B_NORM_END;
         B_NORM_END: state_in = fir_due_ff ? B_FIR : B_IDLE;
         B_FIR: begin
            if (jp_ff == TAP_AW'(TAPS - 1)) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN:   state_in = B_EMIT;
         B_EMIT: begin
            if (slot_free) begin
               state_in = B_IDLE;
            end
         end
         default:   state_in = B_IDLE;
      endcase
   end

   // Outputs of the sequencer: queue pop, multiplier operands and MAC control
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mac   = '0;
      q_pop = 1'b0;
      unique case (state_ff)
         B_IDLE:    q_pop = !q_empty;
         B_MIX_I0: begin
            mul_a = OSC_W'(ci_ff);    mul_b = FACT_W'(osc_r_ff); mac = '{1'b1, 1'b1, 1'b0};
         end
         B_MIX_I1: begin
            mul_a = OSC_W'(cq_ff);    mul_b = FACT_W'(osc_i_ff); mac = '{1'b1, 1'b0, 1'b1};
         end
         B_MIX_Q0: begin
            mul_a = OSC_W'(ci_ff);    mul_b = FACT_W'(osc_i_ff); mac = '{1'b1, 1'b1, 1'b0};
         end
         B_MIX_Q1: begin
            mul_a = OSC_W'(cq_ff);    mul_b = FACT_W'(osc_r_ff); mac = '{1'b1, 1'b0, 1'b0};
         end
         B_ADV_R0: begin
            mul_a = osc_r_ff; mul_b = FACT_W'(cfg.step_cos); mac = '{1'b1, 1'b1, 1'b0};
         end
         B_ADV_R1: begin
            mul_a = osc_i_ff; mul_b = FACT_W'(cfg.step_sin); mac = '{1'b1, 1'b0, 1'b1};
         end
         B_ADV_I0: begin
            mul_a = osc_r_ff; mul_b = FACT_W'(cfg.step_sin); mac = '{1'b1, 1'b1, 1'b0};
         end
         B_ADV_I1: begin
            mul_a = osc_i_ff; mul_b = FACT_W'(cfg.step_cos); mac = '{1'b1, 1'b0, 1'b0};
         end
         B_NORM_M0: begin
            mul_a = osc_r_ff; mul_b = FACT_W'(osc_r_ff); mac = '{1'b1, 1'b1, 1'b0};
         end
         B_NORM_M1: begin
            mul_a = osc_i_ff; mul_b = FACT_W'(osc_i_ff); mac = '{1'b1, 1'b0, 1'b0};
         end
         B_NORM_R: begin
            mul_a = osc_r_ff; mul_b = f_ff; mac = '{1'b1, 1'b1, 1'b0};
         end
         B_NORM_I: begin
            mul_a = osc_i_ff; mul_b = f_ff; mac = '{1'b1, 1'b1, 1'b0};
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Multiply and accumulate
   assign prod     = mul_a * mul_b;
   assign acc_base = mac.clr ? '0 : acc_ff;
   assign acc_in   = mac.sub ? acc_base - OSC_ACC_W'(prod) : acc_base + OSC_ACC_W'(prod);

   // Counter updates at the end of the oscillator pass
   always_comb begin
      renorm_cnt_in = renorm_hit ? '0 : renorm_cnt_ff + 1'b1;
      decim_cnt_in  = fir_hit ? '0 : DCNT_W'(decim_next);
   end

   assign out_valid_in = (state_ff == B_EMIT && slot_free) ? 1'b1 :
                         (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         osc_r_ff      <= OSC_ONE;
         osc_i_ff      <= '0;
         renorm_cnt_ff <= '0;
         decim_cnt_ff  <= '0;
         fir_due_ff    <= 1'b0;
         wp_ff         <= '0;
         line_vld_ff   <= '0;
         coeff_vld_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= (state_ff == B_FIR);
         out_valid_ff <= out_valid_in;
         if (q_pop && q_head.kind == KIND_LOAD) begin
            coeff_vld_ff[q_head.idx] <= 1'b1;
         end
         if (state_ff == B_UPDATE) begin
            osc_r_ff      <= nr_ff;
            osc_i_ff      <= OSC_W'(rnd_sat(acc_ff, 15, W16_MIN, W16_MAX));
            renorm_cnt_ff <= renorm_cnt_in;
            decim_cnt_ff  <= decim_cnt_in;
            fir_due_ff    <= fir_hit;
            wp_ff         <= wp_in;
            line_vld_ff[wp_in] <= 1'b1;
         end
         if (state_ff == B_NORM_END) begin
            osc_r_ff <= rtmp_ff;
            osc_i_ff <= OSC_W'(rnd_sat(acc_ff, 30, W16_MIN, W16_MAX));
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (mac.en) begin
         acc_ff <= acc_in;
      end
      if (q_pop) begin
         ci_ff <= q_head.ci;
         cq_ff <= q_head.cq;
      end
      unique case (state_ff)
         B_MIX_Q0: mi_ff   <= LINE_W'(rnd_sat(acc_ff, 15, MIX_MIN, MIX_MAX));
         B_ADV_R0: mq_ff   <= LINE_W'(rnd_sat(acc_ff, 15, MIX_MIN, MIX_MAX));
         B_ADV_I0: nr_ff   <= OSC_W'(rnd_sat(acc_ff, 15, W16_MIN, W16_MAX));
         B_NORM_F: f_ff    <= FACT_W'((THREE_HALF_SCALE - acc_ff) >>> 1);
         B_NORM_I: rtmp_ff <= OSC_W'(rnd_sat(acc_ff, 30, W16_MIN, W16_MAX));
         default: ;
      endcase
      // Set up read pointers for the filter pass
      if (state_ff == B_UPDATE) begin
         jp_ff <= '0;
         rp_ff <= wp_in;
      end else if (state_ff == B_FIR) begin
         jp_ff <= jp_ff + 1'b1;
         rp_ff <= (rp_ff == TAP_AW'(TAPS - 1)) ? '0 : rp_ff + 1'b1;
      end
   end

   // Tap store and delay line memories
   always_ff @(posedge clock) begin
      if (q_pop && q_head.kind == KIND_LOAD) begin
         coeff_mem[q_head.idx] <= q_head.value;
      end
      if (state_ff == B_UPDATE) begin
         line_mem[wp_in] <= {mi_ff, mq_ff};
      end
      cf_rd_ff <= coeff_mem[jp_ff];
      ln_rd_ff <= line_mem[rp_ff];
      cf_v_ff  <= coeff_vld_ff[jp_ff];
      ln_v_ff  <= line_vld_ff[rp_ff];
   end

   // Entries never written read as zero
   assign cf_use = cf_v_ff ? cf_rd_ff : '0;
   assign li_use = ln_v_ff ? ln_rd_ff[2*LINE_W-1:LINE_W] : '0;
   assign lq_use = ln_v_ff ? ln_rd_ff[LINE_W-1:0] : '0;

   // FIR accumulate, round and hold the result
   always_ff @(posedge clock) begin
      if (state_ff == B_UPDATE) begin
         fir_i_ff <= '0;
         fir_q_ff <= '0;
      end else if (rd_pend_ff) begin
         fir_i_ff <= fir_i_ff + FIR_ACC_W'(FIR_PROD_W'(cf_use * li_use));
         fir_q_ff <= fir_q_ff + FIR_ACC_W'(FIR_PROD_W'(cf_use * lq_use));
      end
      if (state_ff == B_EMIT && slot_free) begin
         out_i_ff <= OUT_W'(rnd_sat(OSC_ACC_W'(fir_i_ff), 9, W16_MIN, W16_MAX));
         out_q_ff <= OUT_W'(rnd_sat(OSC_ACC_W'(fir_q_ff), 9, W16_MIN, W16_MAX));
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.out_i = out_i_ff;
   assign rsp_chan.out_q = out_q_ff;

endmodule

// ----- design/iq_downconvert_decimating_fir.sv -----
// Top level of the IQ downconverter with decimating FIR filter.
// A tap load is written to the tap store as the back part dequeues it. A sample
// runs eight multiply-accumulate steps of the single shared oscillator multiplier
// (mixing and oscillator advance) plus dequeue and update; every 1024th sample
// adds the renormalisation step on the same multiplier. A sample that completes a
// decimation period then runs the filter: 63 taps through one registered read
// port per memory and one MAC pair. Requests pass through a two-entry queue, and
// a finished result waits in the response register without stopping new requests
// from being queued. No clearing pass is needed after reset: tap store and delay
// line entries carry valid bits.
module iq_downconvert_decimating_fir import iqdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   iqdc_req_if.sink              req_chan,
   iqdc_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type   cfg_ff;
   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_entry, q_head;
   logic [DECIM_W-1:0] decim_wr;

   // Clamp decimation to 1..16 on write
   always_comb begin
      decim_wr = csr_write_data[DECIM_W-1:0];
      if (decim_wr == '0) begin
         decim_wr = DECIM_W'(1);
      end else if (decim_wr > DECIM_W'(DECIM_MAX)) begin
         decim_wr = DECIM_W'(DECIM_MAX);
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_cos   <= OSC_ONE;
         cfg_ff.step_sin   <= '0;
         cfg_ff.decimation <= DECIM_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_STEP_COS:   cfg_ff.step_cos   <= csr_write_data;
            CSR_STEP_SIN:   cfg_ff.step_sin   <= csr_write_data;
            CSR_DECIMATION: cfg_ff.decimation <= decim_wr;
            default:        cfg_ff.decimation <= cfg_ff.decimation;
         endcase
      end
   end

   iqdc_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   iqdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   iqdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");

   a_sample_kept : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == ACTION_SAMPLE) |-> q_push)
      else $error("accepted sample transaction not queued");
`endif

endmodule

// ----- verif/tb_iq_downconvert_decimating_fir.sv -----
// Self-checking testbench for the IQ downconverter with decimating FIR filter.
module tb_iq_downconvert_decimating_fir;
   import iqdc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;  // no register behind it
   localparam int SETTLE_CYCLES   = 400;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 170;

   typedef struct {
      logic                      action;
      logic [BYTE_W-1:0]         i_byte;
      logic [BYTE_W-1:0]         q_byte;
      logic [TAP_IDX_W-1:0]      tap_index;
      logic signed [COEFF_W-1:0] tap_value;
   } item_type;

   typedef struct {
      logic signed [OUT_W-1:0] out_i;
      logic signed [OUT_W-1:0] out_q;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   iqdc_req_if req_chan ();
   iqdc_rsp_if rsp_chan ();

   iq_downconvert_decimating_fir u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Mirror of the block's state
   longint step_cos_m, step_sin_m, osc_re, osc_im;
   logic [DECIM_W-1:0] decim_reg;
   int renorm_cnt, decim_cnt;
   longint delay_i [TAPS];
   longint delay_q [TAPS];
   longint taps_m [TAPS];

   item_type     pending_items[$];
   filtered_type expected_outputs[$];
   int  failures = 0;
   bit  no_idle = 1'b0;
   bit  hold_request = 1'b0;

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Append a transaction to the driver's backlog
   task automatic enqueue(item_type it);
      pending_items.insert(pending_items.size(), it);
   endtask

   // Advance the mirrored state by one accepted transaction
   task automatic predict_downconvert(item_type it);
      longint ci, cq, mi, mq, nr, ni, m, f, acc_i, acc_q;
      int d;
      filtered_type res;
      if (it.action == ACTION_LOAD) begin
         if (it.tap_index < TAPS) taps_m[it.tap_index] = it.tap_value;
         return;
      end
      ci = 2 * longint'(it.i_byte) - 255;
      cq = 2 * longint'(it.q_byte) - 255;
      mi = clamp(round_shift(ci * osc_re - cq * osc_im, 15), -512, 511);
      mq = clamp(round_shift(ci * osc_im + cq * osc_re, 15), -512, 511);
      nr = clamp(round_shift(osc_re * step_cos_m - osc_im * step_sin_m, 15), -32768, 32767);
      ni = clamp(round_shift(osc_re * step_sin_m + osc_im * step_cos_m, 15), -32768, 32767);
      osc_re = nr;
      osc_im = ni;
      renorm_cnt++;
      if (renorm_cnt >= RENORM_PERIOD) begin
         renorm_cnt = 0;
         m = osc_re * osc_re + osc_im * osc_im;
         f = ((longint'(3) <<< 30) - m) / 2;
         osc_re = clamp(round_shift(osc_re * f, 30), -32768, 32767);
         osc_im = clamp(round_shift(osc_im * f, 30), -32768, 32767);
      end
      for (int j = TAPS - 1; j > 0; j--) begin
         delay_i[j] = delay_i[j-1];
         delay_q[j] = delay_q[j-1];
      end
      delay_i[0] = mi;
      delay_q[0] = mq;
      d = (decim_reg == 0) ? 1 : (decim_reg > DECIM_MAX ? DECIM_MAX : int'(decim_reg));
      decim_cnt++;
      if (decim_cnt < d) return;
      decim_cnt = 0;
      acc_i = 0;
      acc_q = 0;
      for (int j = 0; j < TAPS; j++) begin
         acc_i += taps_m[j] * delay_i[j];
         acc_q += taps_m[j] * delay_q[j];
      end
      res.out_i = OUT_W'(clamp(round_shift(acc_i, 9), -32768, 32767));
      res.out_q = OUT_W'(clamp(round_shift(acc_q, 9), -32768, 32767));
      expected_outputs.insert(expected_outputs.size(), res);
   endtask

   // Write one register at the falling edge and mirror it
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_STEP_COS:   step_cos_m = longint'($signed(data));
         CSR_STEP_SIN:   step_sin_m = longint'($signed(data));
         CSR_DECIMATION: decim_reg  = data[DECIM_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic item_type sample_item(int i_val, int q_val);
      item_type it;
      it.action    = ACTION_SAMPLE;
      it.i_byte    = BYTE_W'(i_val);
      it.q_byte    = BYTE_W'(q_val);
      it.tap_index = TAP_IDX_W'($urandom);
      it.tap_value = COEFF_W'($urandom);
      return it;
   endfunction

   function automatic item_type load_item(int idx, int value);
      item_type it;
      it.action    = ACTION_LOAD;
      it.i_byte    = BYTE_W'($urandom);
      it.q_byte    = BYTE_W'($urandom);
      it.tap_index = TAP_IDX_W'(idx);
      it.tap_value = COEFF_W'(value);
      return it;
   endfunction

   // Wait for the block to drain, then let any trailing work finish
   task automatic wait_idle();
      wait (pending_items.size() == 0 && !req_chan.valid && expected_outputs.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stimulus sequence
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.action    = ACTION_SAMPLE;
      req_chan.i_byte    = '0;
      req_chan.q_byte    = '0;
      req_chan.tap_index = '0;
      req_chan.tap_value = '0;
      rsp_chan.ready     = 1'b0;
      step_cos_m = 32767;
      step_sin_m = 0;
      decim_reg  = DECIM_RESET;
      osc_re = 32767;
      osc_im = 0;
      renorm_cnt = 0;
      decim_cnt  = 0;
      for (int j = 0; j < TAPS; j++) begin
         delay_i[j] = 0;
         delay_q[j] = 0;
         taps_m[j]  = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: tap extremes, ignored out-of-range tap, byte extremes
      enqueue(sample_item(255, 255));  // taps still zero
      enqueue(load_item(0, 32767));
      enqueue(load_item(1, -32768));
      enqueue(load_item(62, 32767));
      enqueue(load_item(2, -32768));
      enqueue(load_item(63, 12345));
      enqueue(load_item(3, 0));
      enqueue(load_item(4, 1));
      enqueue(load_item(5, -1));
      enqueue(sample_item(0, 0));
      enqueue(sample_item(255, 255));
      enqueue(sample_item(0, 255));
      enqueue(sample_item(255, 0));
      enqueue(sample_item(127, 128));
      enqueue(sample_item(128, 127));
      enqueue(sample_item(170, 85));
      enqueue(sample_item(85, 170));
      enqueue(sample_item(255, 255));
      enqueue(sample_item(255, 255));
      enqueue(sample_item(0, 0));
      wait_idle();

      // Fill every tap before the random part
      write_register(CSR_SPARE, 16'hFFFF);
      for (int j = 0; j < TAPS; j++) enqueue(load_item(j, $urandom));
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               write_register(CSR_STEP_COS, 16'h7FFF);
               write_register(CSR_STEP_SIN, 16'h0000);
               write_register(CSR_DECIMATION, 5'd3);
            end
            1: begin
               write_register(CSR_STEP_COS, 16'h8000);
               write_register(CSR_STEP_SIN, 16'h8000);
               write_register(CSR_DECIMATION, 5'd16);
            end
            2: begin
               write_register(CSR_STEP_COS, 16'h5A82);
               write_register(CSR_STEP_SIN, 16'h5A82);
               write_register(CSR_DECIMATION, 5'd0);
            end
            3: begin
               write_register(CSR_STEP_COS, 16'h7FF6);
               write_register(CSR_STEP_SIN, 16'h0324);
               write_register(CSR_DECIMATION, 5'd31);
               hold_request = 1'b1;
            end
            4: begin
               write_register(CSR_STEP_COS, 16'h0000);
               write_register(CSR_STEP_SIN, 16'h7FFF);
               write_register(CSR_DECIMATION, 5'd2);  // lowered below a running count
               no_idle = 1'b1;
            end
            default: begin
               write_register(CSR_STEP_COS, CSR_DATA_W'($urandom));
               write_register(CSR_STEP_SIN, CSR_DATA_W'($urandom));
               write_register(CSR_DECIMATION, DECIM_W'($urandom_range(1, 17)));
               no_idle = 1'b0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 8)
               enqueue(load_item($urandom_range(0, 63), $urandom));
            else
               enqueue(sample_item($urandom_range(0, 255), $urandom_range(0, 255)));
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("iq_downconvert_decimating_fir verification clean");
      end else begin
         $display("iq_downconvert_decimating_fir verification failed");
      end
      $finish;
   end

   // Request driver: hold until accepted, then idle a drawn gap
   bit req_fire = 1'b0;
   int req_gap = 0;
   always @(posedge clock) begin
      req_fire <= req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_fire) begin
         // hold the offered transaction
      end else if (req_gap > 0) begin
         req_chan.valid <= 1'b0;
         req_gap--;
      end else if (pending_items.size() > 0) begin
         item_type it;
         it = pending_items.pop_front();
         req_chan.valid     <= 1'b1;
         req_chan.action    <= it.action;
         req_chan.i_byte    <= it.i_byte;
         req_chan.q_byte    <= it.q_byte;
         req_chan.tap_index <= it.tap_index;
         req_chan.tap_value <= it.tap_value;
         req_gap = no_idle ? 0 : $urandom_range(0, 8);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response ready: drawn stalls, plus one long hold-off on request
   bit rsp_fire = 1'b0;
   int rsp_stall = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      rsp_fire <= rsp_chan.valid && rsp_chan.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_fire) rsp_stall = no_idle ? 0 : $urandom_range(0, 8);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on accepted requests, compare accepted results
   int idle_cycles = 0;
   always @(posedge clock) begin
      item_type it;
      filtered_type exp_res;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            it.action    = req_chan.action;
            it.i_byte    = req_chan.i_byte;
            it.q_byte    = req_chan.q_byte;
            it.tap_index = req_chan.tap_index;
            it.tap_value = req_chan.tap_value;
            predict_downconvert(it);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected result out_i=%0d out_q=%0d",
                      rsp_chan.out_i, rsp_chan.out_q);
               failures++;
            end else begin
               exp_res = expected_outputs.pop_front();
               if (rsp_chan.out_i !== exp_res.out_i) begin
                  $error("out_i expected %0d actual %0d", exp_res.out_i, rsp_chan.out_i);
                  failures++;
               end
               if (rsp_chan.out_q !== exp_res.out_q) begin
                  $error("out_q expected %0d actual %0d", exp_res.out_q, rsp_chan.out_q);
                  failures++;
               end
            end
         end
         // Watchdog on cycles with no transaction on either channel
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("iq_downconvert_decimating_fir verification failed");
            $finish;
         end
      end
   end

endmodule
